// File: hdl/ymodem_block_receiver_defines.svh
// assertion macros for the ymodem block receiver checker
`ifndef YMODEM_BLOCK_RECEIVER_DEFINES_SVH
`define YMODEM_BLOCK_RECEIVER_DEFINES_SVH

// clocked check, off while reset is low
`define RXB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define RXB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/rxb_pkg.sv
// shared types, constants and helpers for the ymodem block receiver
package rxb_pkg;

    localparam int SHORT_BLOCK = 128;
    localparam int LONG_BLOCK  = 1024;
    localparam int HEADER_SCAN = 128;
    localparam int NAME_BYTES  = 11;
    localparam int MAX_RESULTS = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_REQ = 8'h43;
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;

    localparam logic [3:0] K_SEND   = 4'd0;
    localparam logic [3:0] K_STORE  = 4'd1;
    localparam logic [3:0] K_TRUNC  = 4'd2;
    localparam logic [3:0] K_NAME   = 4'd3;
    localparam logic [3:0] K_OPEN   = 4'd4;
    localparam logic [3:0] K_DONE   = 4'd5;
    localparam logic [3:0] K_CANCEL = 4'd6;
    localparam logic [3:0] K_FLUSH  = 4'd7;
    localparam logic [3:0] K_FDONE  = 4'd8;

    localparam logic [2:0] REG_HDR_TO  = 3'd0;
    localparam logic [2:0] REG_SEQ_TO  = 3'd1;
    localparam logic [2:0] REG_DATA_TO = 3'd2;
    localparam logic [2:0] REG_HDR_LIM = 3'd3;
    localparam logic [2:0] REG_ERR_LIM = 3'd4;

    localparam logic OP_BYTE = 1'b0;

    typedef enum logic [3:0] {
        PH_HEADER, PH_SEQ1, PH_SEQ2_OK, PH_SEQ2_BAD, PH_PAYLOAD,
        PH_CRC1, PH_CRC2, PH_EOT2, PH_DRAIN, PH_HALTED
    } t_phase;

    typedef struct packed {
        logic [15:0] hdr_to;
        logic [15:0] seq_to;
        logic [15:0] data_to;
        logic [4:0]  hdr_lim;
        logic [4:0]  err_lim;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  value;
        logic [31:0] offset;
        logic [31:0] file_length;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [2:0]               count;
        t_result [MAX_RESULTS-1:0] res;
    } t_bundle;

    function automatic t_result res_mk(logic [3:0] kind, logic [7:0] value,
                                       logic [31:0] offset, logic [31:0] flen);
        t_result r;
        r.kind        = kind;
        r.value       = value;
        r.offset      = offset;
        r.file_length = flen;
        r.last        = 1'b0;
        return r;
    endfunction

    // crc-16/xmodem, one byte
    function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: hdl/rxb_front.sv
// protocol engine: takes one byte or tick per beat and builds its result bundle
module rxb_front import rxb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_byte,
    input  logic        i_q_full,
    output logic        o_push,
    output t_bundle     o_bundle
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_seq, n_seq;
    logic [4:0]  r_retry, n_retry;
    logic        r_hdr, n_hdr;
    logic        r_await, n_await;
    logic        r_long, n_long;
    logic [10:0] r_pcnt, n_pcnt;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_crcrx, n_crcrx;
    logic [31:0] r_wr, n_wr;
    logic [31:0] r_com, n_com;
    logic [31:0] r_size, n_size;
    logic        r_namep, n_namep;
    logic [1:0]  r_spp, n_spp;
    logic [15:0] r_tick, n_tick;

    t_result [MAX_RESULTS-1:0] v_res;
    logic [2:0]  v_n;
    logic        do_fail, do_eot2, do_cancel;
    logic [15:0] v_limit;
    logic [7:0]  c;
    logic [3:0]  d;
    logic        digit;
    logic [31:0] thr;
    logic        fire;

    assign o_ready = i_rst_n && !i_q_full;
    assign fire    = i_valid && o_ready;

    function automatic logic [15:0] cfg_limit(t_phase ph, t_cfg cfg);
        logic [15:0] l;
        case (ph)
            PH_SEQ1, PH_SEQ2_OK, PH_SEQ2_BAD: l = cfg.seq_to;
            PH_PAYLOAD, PH_CRC1, PH_CRC2:     l = cfg.data_to;
            default:                          l = cfg.hdr_to;
        endcase
        return l;
    endfunction

    always_comb begin
        n_phase = r_phase; n_seq = r_seq; n_retry = r_retry; n_hdr = r_hdr;
        n_await = r_await; n_long = r_long; n_pcnt = r_pcnt; n_crc = r_crc;
        n_crcrx = r_crcrx; n_wr = r_wr; n_com = r_com; n_size = r_size;
        n_namep = r_namep; n_spp = r_spp; n_tick = r_tick;
        v_res = '0; v_n = '0;
        do_fail = 1'b0; do_eot2 = 1'b0; do_cancel = 1'b0;
        v_limit = cfg_limit(r_phase, i_cfg);
        c = (r_pcnt == 11'(HEADER_SCAN - 1)) ? 8'h00 : i_byte;
        d = c[3:0];
        digit = (c >= 8'h30) && (c <= 8'h39);
        thr = (d > 4'd5) ? 32'd429496728 : 32'd429496729;

        if (i_op == OP_BYTE) begin
            case (r_phase)
                PH_HEADER: begin
                    if (i_byte == CH_EOT) begin
                        v_res[v_n] = res_mk(K_SEND, CH_NAK, '0, '0); v_n = v_n + 3'd1;
                        n_phase = PH_EOT2; n_tick = '0;
                    end else if (i_byte == CH_SOH || i_byte == CH_STX) begin
                        n_long = (i_byte == CH_STX);
                        n_phase = PH_SEQ1; n_tick = '0;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_SEQ1: n_phase = (i_byte == r_seq) ? PH_SEQ2_OK : PH_SEQ2_BAD;
                PH_SEQ2_OK, PH_SEQ2_BAD: begin
                    if (r_phase == PH_SEQ2_OK && i_byte == ~r_seq) begin
                        n_phase = PH_PAYLOAD; n_pcnt = '0; n_crc = '0; n_tick = '0;
                        if (r_hdr) begin
                            n_await = 1'b1; n_namep = 1'b0; n_spp = '0;
                            n_size = '0; n_wr = '0; n_com = '0;
                        end
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_crc = crc_byte(r_crc, i_byte);
                    if (r_hdr) begin
                        if (r_pcnt < 11'(HEADER_SCAN)) begin
                            case (r_spp)
                                2'd0: begin
                                    if (c == 8'h00) begin
                                        n_spp = 2'd1; n_await = 1'b0;
                                    end else if (r_await && r_pcnt < 11'(NAME_BYTES)) begin
                                        if (r_pcnt == '0) n_namep = 1'b1;
                                        v_res[v_n] = res_mk(K_NAME, c, 32'(r_pcnt), '0);
                                        v_n = v_n + 3'd1;
                                        if (r_pcnt + 11'd1 >= 11'(NAME_BYTES)) n_await = 1'b0;
                                    end
                                end
                                2'd1: begin
                                    if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
                                        n_spp = 2'd1;
                                    end else if (digit) begin
                                        n_size = 32'(d); n_spp = 2'd2;
                                    end else begin
                                        n_size = '0; n_spp = 2'd3;
                                    end
                                end
                                2'd2: begin
                                    if (digit) begin
                                        if (r_size > thr) n_size = 32'hFFFF_FFFF;
                                        else n_size = {r_size[28:0], 3'b000}
                                                    + {r_size[30:0], 1'b0} + 32'(d);
                                    end else begin
                                        n_spp = 2'd3;
                                    end
                                end
                                default: n_spp = r_spp;
                            endcase
                        end
                    end else if (r_size == '0 || r_wr < r_size) begin
                        v_res[v_n] = res_mk(K_STORE, i_byte, r_wr, '0); v_n = v_n + 3'd1;
                        n_wr = r_wr + 32'd1;
                    end
                    n_pcnt = r_pcnt + 11'd1;
                    if (n_pcnt >= (r_long ? 11'(LONG_BLOCK) : 11'(SHORT_BLOCK))) begin
                        n_phase = PH_CRC1; n_tick = '0;
                    end else if (n_pcnt[$clog2(SHORT_BLOCK)-1:0] == '0) begin
                        n_tick = '0;
                    end
                end
                PH_CRC1: begin
                    n_crcrx = {i_byte, 8'h00}; n_phase = PH_CRC2;
                end
                PH_CRC2: begin
                    n_crcrx = {r_crcrx[15:8], i_byte};
                    if (n_crcrx == r_crc) begin
                        v_res[v_n] = res_mk(K_SEND, CH_ACK, '0, '0); v_n = v_n + 3'd1;
                        n_retry = '0;
                        n_phase = PH_HEADER; n_tick = '0;
                        n_seq = r_seq + 8'd1;
                        if (r_hdr) begin
                            if (!r_namep) begin
                                v_res[v_n] = res_mk(K_SEND, CH_ACK, '0, '0); v_n = v_n + 3'd1;
                                v_res[v_n] = res_mk(K_DONE, '0, '0, '0); v_n = v_n + 3'd1;
                                n_phase = PH_HALTED; n_seq = r_seq; n_tick = r_tick;
                            end else begin
                                v_res[v_n] = res_mk(K_SEND, CH_REQ, '0, '0); v_n = v_n + 3'd1;
                                v_res[v_n] = res_mk(K_OPEN, '0, '0, r_size); v_n = v_n + 3'd1;
                                n_hdr = 1'b0;
                            end
                        end else begin
                            n_com = r_wr;
                        end
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_EOT2:  do_eot2 = 1'b1;
                PH_DRAIN: n_phase = PH_HALTED;
                default:  n_phase = r_phase;
            endcase
        end else if (r_phase != PH_HALTED) begin
            n_tick = (r_tick != 16'hFFFF) ? r_tick + 16'd1 : r_tick;
            if (n_tick >= v_limit) begin
                case (r_phase)
                    PH_HEADER: begin
                        v_res[v_n] = res_mk(K_SEND, r_hdr ? CH_REQ : CH_NAK, '0, '0);
                        v_n = v_n + 3'd1;
                        n_retry = (r_retry != 5'd31) ? r_retry + 5'd1 : r_retry;
                        n_tick = '0;
                        if (n_retry >= i_cfg.hdr_lim) do_cancel = 1'b1;
                    end
                    PH_EOT2:  do_eot2 = 1'b1;
                    PH_DRAIN: n_phase = PH_HALTED;
                    default:  do_fail = 1'b1;
                endcase
            end
        end

        if (do_eot2) begin
            v_res[v_n] = res_mk(K_SEND, CH_ACK, '0, '0); v_n = v_n + 3'd1;
            if (!r_hdr) begin
                v_res[v_n] = res_mk(K_FDONE, '0, '0, '0); v_n = v_n + 3'd1;
            end
            n_retry = '0; n_seq = '0; n_hdr = 1'b1; n_await = 1'b1;
            v_res[v_n] = res_mk(K_SEND, CH_REQ, '0, '0); v_n = v_n + 3'd1;
            n_phase = PH_HEADER; n_tick = '0;
        end

        if (do_fail) begin
            if (!r_hdr && r_wr != r_com) begin
                n_wr = r_com;
                v_res[v_n] = res_mk(K_TRUNC, '0, r_com, '0); v_n = v_n + 3'd1;
            end
            v_res[v_n] = res_mk(K_FLUSH, '0, '0, '0); v_n = v_n + 3'd1;
            v_res[v_n] = res_mk(K_SEND, CH_NAK, '0, '0); v_n = v_n + 3'd1;
            n_await = r_hdr;
            n_retry = (r_retry != 5'd31) ? r_retry + 5'd1 : r_retry;
            if (n_retry >= i_cfg.err_lim) begin
                do_cancel = 1'b1;
            end else begin
                n_phase = PH_HEADER; n_tick = '0;
            end
        end

        if (do_cancel) begin
            v_res[v_n] = res_mk(K_SEND, CH_CAN, '0, '0); v_n = v_n + 3'd1;
            v_res[v_n] = res_mk(K_SEND, CH_CAN, '0, '0); v_n = v_n + 3'd1;
            v_res[v_n] = res_mk(K_CANCEL, '0, '0, '0); v_n = v_n + 3'd1;
            n_phase = PH_DRAIN; n_tick = '0;
        end

        if (v_n != '0) v_res[v_n - 3'd1].last = 1'b1;
    end

    assign o_push         = fire && (v_n != '0);
    assign o_bundle.count = v_n;
    assign o_bundle.res   = v_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_seq <= '0; r_retry <= '0; r_hdr <= 1'b1;
            r_await <= 1'b1; r_long <= 1'b0; r_pcnt <= '0; r_crc <= '0;
            r_crcrx <= '0; r_wr <= '0; r_com <= '0; r_size <= '0;
            r_namep <= 1'b0; r_spp <= '0; r_tick <= '0;
        end else if (fire) begin
            r_phase <= n_phase; r_seq <= n_seq; r_retry <= n_retry; r_hdr <= n_hdr;
            r_await <= n_await; r_long <= n_long; r_pcnt <= n_pcnt; r_crc <= n_crc;
            r_crcrx <= n_crcrx; r_wr <= n_wr; r_com <= n_com; r_size <= n_size;
            r_namep <= n_namep; r_spp <= n_spp; r_tick <= n_tick;
        end
    end

endmodule

// File: hdl/rxb_queue.sv
// short bundle queue between the engine and the result serializer
module rxb_queue import rxb_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_bundle o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hdl/rxb_back.sv
// result serializer: sends one result of the held bundle per beat
module rxb_back import rxb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_bundle     i_data,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [79:0] o_tdata,
    output logic        o_tlast
);

    t_bundle    r_b;
    logic       r_valid;
    logic [2:0] r_idx;
    t_result    cur;
    logic       done;

    assign cur      = r_b.res[r_idx];
    assign done     = r_valid && i_tready && (r_idx == r_b.count - 3'd1);
    assign o_pop    = !i_empty && (!r_valid || done);
    assign o_tvalid = r_valid;
    assign o_tdata  = {4'd0, cur.file_length, cur.offset, cur.value, cur.kind};
    assign o_tlast  = cur.last;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_b <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0; r_idx <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1; r_idx <= '0;
        end else if (done) begin
            r_valid <= 1'b0; r_idx <= '0;
        end else if (r_valid && i_tready) begin
            r_idx <= r_idx + 3'd1;
        end
    end

endmodule

// File: hdl/ymodem_block_receiver.sv
// ymodem block receiver top level: config registers, engine, queue, serializer
//
// channel   dir  handshake                  payload
// s_axis    in   i_s_tvalid / o_s_tready    tdata rx_byte, tuser op
// m_axis    out  o_m_tvalid / i_m_tready    tdata kind,value,offset,file_length; tlast
// cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// the engine takes one byte or tick beat per cycle while the bundle queue has room
// each item leaves 0 to 6 result beats; the serializer sends one per cycle while i_m_tready is high
// so input runs at one beat per cycle only while the output keeps up, output set by result count
// reset is synchronous active low, no clearing pass, ready from the first cycle after reset
// either side may stall; the queue and serializer hold bundles meanwhile
module ymodem_block_receiver import rxb_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tuser,   // [0] op: 0 byte, 1 tick
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // [3:0] kind, [11:4] value, [43:12] offset,
                                     // [75:44] file_length, [79:76] zero
    output logic        o_m_tlast,   // last result of the item
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    q_full, q_empty, q_push, q_pop;
    t_bundle push_b, pop_b;

    // config is accepted whenever out of reset; unknown indexes are dropped
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_to  <= 16'd1000;
            r_cfg.seq_to  <= 16'd300;
            r_cfg.data_to <= 16'd1000;
            r_cfg.hdr_lim <= 5'd25;
            r_cfg.err_lim <= 5'd5;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HDR_TO:  r_cfg.hdr_to  <= i_cfg_data;
                REG_SEQ_TO:  r_cfg.seq_to  <= i_cfg_data;
                REG_DATA_TO: r_cfg.data_to <= i_cfg_data;
                REG_HDR_LIM: r_cfg.hdr_lim <= i_cfg_data[4:0];
                REG_ERR_LIM: r_cfg.err_lim <= i_cfg_data[4:0];
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    // front: framing, crc, header parse, retries
    rxb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_op     (i_s_tuser),
        .i_byte   (i_s_tdata),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_bundle (push_b)
    );

    // bundles of results waiting for the output side
    rxb_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_b),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (pop_b)
    );

    // back: one result beat per cycle while the sink is ready
    rxb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_data   (pop_b),
        .o_pop    (q_pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

endmodule

// File: hdl/rxb_checker.sv
// port-level checks for the ymodem block receiver, bound to the top level
`include "ymodem_block_receiver_defines.svh"

module rxb_checker import rxb_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [79:0] o_m_tdata,
    input logic        o_m_tlast
);

    `RXB_ASSERT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result beat dropped while stalled")
    `RXB_ASSERT(a_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast), "stalled result changed")
    `RXB_ASSERT(a_kind, i_clk, i_rst_n, o_m_tvalid |-> o_m_tdata[3:0] <= K_FDONE, "unknown result kind")
    `RXB_ASSERT(a_len, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[3:0] != K_OPEN |-> o_m_tdata[75:44] == 32'd0, "file length outside file open")

endmodule

bind ymodem_block_receiver rxb_checker u_rxb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
